>>> rtl/core/binomial_coefficient_pascal_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef BINOMIAL_COEFFICIENT_PASCAL_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_PASCAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/bcp_pkg.sv
package bcp_pkg;

	// Scratch row geometry.
	localparam int ROW_DEPTH = 64;
	localparam int ADDR_W    = 6;
	localparam int ENTRY_W   = 64;
	localparam int COEFF_W   = 60;

	// Query beat.
	typedef struct packed {
		logic [5:0] degree;
		logic [5:0] coeff_index;
	} bcp_in_t;

	// Result beat.
	typedef struct packed {
		logic [COEFF_W-1:0] coefficient;
		logic               out_of_range;
	} bcp_out_t;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ROW   = 6'b000010,
		ST_PRIME = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_RES   = 6'b010000,
		ST_OUT   = 6'b100000
	} bcp_state_t;

endpackage

>>> rtl/core/binomial_coefficient_pascal.sv
// Channel | Direction | Handshake                   | Payload
// query   | in        | query_valid / query_ready   | bcp_pkg::bcp_in_t  (degree, coeff_index)
// result  | out       | result_valid / result_ready | bcp_pkg::bcp_out_t (coefficient, out_of_range)
//
// The degree is clamped to the lesser of MAX_DEGREE and ROW_DEPTH - 1. An index past the
// degree skips the final memory read. The single adder and the single read port of the row
// memory together update one row entry per cycle. query_ready is high only while the block
// is idle.
// A result is held in its output register until result_ready; a stalled result blocks the next
// query. Reset clears the sequencer only; the row memory needs no clearing.
module binomial_coefficient_pascal #(
	parameter int MAX_DEGREE = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_ready,
	input  bcp_pkg::bcp_in_t  query,
	output logic              result_valid,
	input  logic              result_ready,
	output bcp_pkg::bcp_out_t result
);

	localparam int AW = bcp_pkg::ADDR_W;
	localparam int EW = bcp_pkg::ENTRY_W;
	localparam logic [AW-1:0] DEG_LIM = AW'((MAX_DEGREE > bcp_pkg::ROW_DEPTH - 1) ?
		(bcp_pkg::ROW_DEPTH - 1) : MAX_DEGREE);

	bcp_pkg::bcp_state_t state_q, state_d;
	logic [AW:0]         row_q, row_d;
	logic [AW-1:0]       col_q, col_d;
	logic [AW-1:0]       deg_q, deg_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [EW-1:0]       carry_q, carry_d;
	bcp_pkg::bcp_out_t   res_q, res_d;

	logic [EW-1:0] row_store [bcp_pkg::ROW_DEPTH];
	logic [EW-1:0] rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [EW-1:0] mem_wd;
	logic [AW-1:0] mem_ra;

	// Scratch row memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_store[mem_wa] <= mem_wd;
		end
		rd_q <= row_store[mem_ra];
	end

	// Sequencer: each row starts with its right edge, then walks right to left
	// adding the old left neighbor to the carried old entry.
	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		col_d   = col_q;
		deg_d   = deg_q;
		idx_d   = idx_q;
		carry_d = carry_q;
		res_d   = res_q;
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = '0;
		mem_ra  = '0;
		case (state_q)
			bcp_pkg::ST_IDLE: begin
				if (query_valid) begin
					mem_we  = 1'b1;
					mem_wa  = '0;
					mem_wd  = EW'(1);
					deg_d   = (query.degree > DEG_LIM) ? DEG_LIM : query.degree;
					idx_d   = query.coeff_index;
					row_d   = (AW+1)'(1);
					state_d = bcp_pkg::ST_ROW;
				end
			end
			bcp_pkg::ST_ROW: begin
				if (row_q > {1'b0, deg_q}) begin
					if (idx_q > deg_q) begin
						res_d.coefficient  = '0;
						res_d.out_of_range = 1'b1;
						state_d            = bcp_pkg::ST_OUT;
					end else begin
						mem_ra  = idx_q;
						state_d = bcp_pkg::ST_RES;
					end
				end else begin
					mem_we  = 1'b1;
					mem_wa  = row_q[AW-1:0];
					mem_wd  = EW'(1);
					mem_ra  = row_q[AW-1:0] - AW'(1);
					col_d   = row_q[AW-1:0] - AW'(1);
					state_d = bcp_pkg::ST_PRIME;
				end
			end
			bcp_pkg::ST_PRIME: begin
				carry_d = rd_q;
				if (col_q == '0) begin
					row_d   = row_q + (AW+1)'(1);
					state_d = bcp_pkg::ST_ROW;
				end else begin
					mem_ra  = col_q - AW'(1);
					state_d = bcp_pkg::ST_ADD;
				end
			end
			bcp_pkg::ST_ADD: begin
				mem_we  = 1'b1;
				mem_wa  = col_q;
				mem_wd  = carry_q + rd_q;
				carry_d = rd_q;
				col_d   = col_q - AW'(1);
				if (col_q == AW'(1)) begin
					row_d   = row_q + (AW+1)'(1);
					state_d = bcp_pkg::ST_ROW;
				end else begin
					mem_ra = col_q - AW'(2);
				end
			end
			bcp_pkg::ST_RES: begin
				res_d.coefficient  = rd_q[bcp_pkg::COEFF_W-1:0];
				res_d.out_of_range = 1'b0;
				state_d            = bcp_pkg::ST_OUT;
			end
			bcp_pkg::ST_OUT: begin
				if (result_ready) begin
					state_d = bcp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bcp_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		row_q   <= row_d;
		col_q   <= col_d;
		deg_q   <= deg_d;
		idx_q   <= idx_d;
		carry_q <= carry_d;
		res_q   <= res_d;
	end

	assign query_ready  = (state_q == bcp_pkg::ST_IDLE);
	assign result_valid = (state_q == bcp_pkg::ST_OUT);
	assign result       = res_q;

endmodule

>>> rtl/core/bcp_checker.sv
`include "binomial_coefficient_pascal_defines.svh"

// Port-level checks for the binomial coefficient block.
module bcp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              query_valid,
	input logic              query_ready,
	input logic              result_valid,
	input logic              result_ready,
	input bcp_pkg::bcp_out_t result
);

	// The block holds one query at a time.
	`BCP_ASSERT_SAME(a_one_in_flight, clk, arst_n, result_valid, !query_ready, "query taken while result pending")

	// An accepted query is never answered in the following cycle.
	`BCP_ASSERT_NEXT(a_not_instant, clk, arst_n, query_valid && query_ready, !result_valid && !query_ready, "result too early")

	// A range miss carries a zero coefficient.
	`BCP_ASSERT_SAME(a_oor_zero, clk, arst_n, result_valid && result.out_of_range, result.coefficient == '0, "nonzero coefficient on range miss")

	// A coefficient inside the row is never zero.
	`BCP_ASSERT_SAME(a_in_range_nonzero, clk, arst_n, result_valid && !result.out_of_range, result.coefficient != '0, "zero coefficient in range")

	// A stalled result beat holds.
	`BCP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

endmodule

bind binomial_coefficient_pascal bcp_checker u_bcp_checker (.*);

>>> sim/tb_binomial_coefficient_pascal.sv
module tb_binomial_coefficient_pascal;

	localparam int MAX_DEGREE   = 63;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2300;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int RANDOM_ITEMS = 260;

	// Receiver stall patterns.
	typedef enum int {
		RX_STREAM,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              query_valid  = 1'b0;
	logic              query_ready;
	bcp_pkg::bcp_in_t  query        = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	bcp_pkg::bcp_out_t result;

	bcp_pkg::bcp_out_t           coeff_expected [$];
	logic [bcp_pkg::ENTRY_W-1:0] pascal_row     [bcp_pkg::ROW_DEPTH];
	int                          error_count  = 0;
	int                          cycle_count  = 0;
	int                          burst_left   = 0;
	bit                          hold_req     = 1'b0;

	binomial_coefficient_pascal #(
		.MAX_DEGREE(MAX_DEGREE)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.query       (query),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #5 clk = ~clk;

	// Abort the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Builds row n of the triangle in place, right to left, and picks entry k.
	function automatic bcp_pkg::bcp_out_t pascal_coeff(bcp_pkg::bcp_in_t q);
		int unsigned       n;
		int unsigned       lim;
		bcp_pkg::bcp_out_t r;
		lim = (MAX_DEGREE < bcp_pkg::ROW_DEPTH - 1) ? MAX_DEGREE : bcp_pkg::ROW_DEPTH - 1;
		n = q.degree;
		if (n > lim)
			n = lim;
		pascal_row[0] = 1;
		for (int i = 1; i <= n; i++) begin
			pascal_row[i] = 1;
			for (int c = i - 1; c >= 1; c--)
				pascal_row[c] = pascal_row[c] + pascal_row[c - 1];
		end
		if (q.coeff_index > n) begin
			r.coefficient  = '0;
			r.out_of_range = 1'b1;
		end else begin
			r.coefficient  = pascal_row[q.coeff_index][bcp_pkg::COEFF_W-1:0];
			r.out_of_range = 1'b0;
		end
		return r;
	endfunction

	// Offers one query beat and returns at the edge where it is taken.
	task automatic send_query(input bcp_pkg::bcp_in_t q);
		query_valid <= 1'b1;
		query       <= q;
		do
			@(posedge clk);
		while (!query_ready);
		coeff_expected.push_back(pascal_coeff(q));
	endtask

	// Sends in bursts of random length, with random gaps between bursts.
	task automatic offer_query(input logic [5:0] degree, input logic [5:0] index);
		bcp_pkg::bcp_in_t q;
		int               gap;
		q.degree      = degree;
		q.coeff_index = index;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				query_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		send_query(q);
		burst_left--;
	endtask

	// Result check: each result beat against the oldest expectation.
	always @(posedge clk) begin : result_check
		bcp_pkg::bcp_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (coeff_expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, got coefficient %0d flag %0b",
					$time, result.coefficient, result.out_of_range);
				error_count++;
			end else begin
				want = coeff_expected.pop_front();
				if (result.coefficient !== want.coefficient) begin
					$display("%0t: coefficient mismatch, expected %0d, got %0d",
						$time, want.coefficient, result.coefficient);
					error_count++;
				end
				if (result.out_of_range !== want.out_of_range) begin
					$display("%0t: out_of_range mismatch, expected %0b, got %0b",
						$time, want.out_of_range, result.out_of_range);
					error_count++;
				end
			end
		end
	end

	// Receiver: stretches of streaming, coin-flip and sparse acceptance,
	// plus one long hold-off when a test asks for it.
	initial begin : ready_pattern
		rx_mode_t mode;
		int       stretch;
		wait (arst_n === 1'b1);
		forever begin
			mode    = rx_mode_t'($urandom_range(0, 2));
			stretch = $urandom_range(20, 200);
			repeat (stretch) begin
				@(posedge clk);
				if (hold_req) begin
					result_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_req = 1'b0;
				end else begin
					case (mode)
						RX_STREAM: result_ready <= 1'b1;
						RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
						default:   result_ready <= ($urandom_range(0, 7) == 0);
					endcase
				end
			end
		end
	end

	// Field extremes, edge indexes, index past the degree, alternating bits.
	task automatic test_directed_queries();
		offer_query(6'd0,  6'd0);
		offer_query(6'd0,  6'd63);
		offer_query(6'd1,  6'd0);
		offer_query(6'd1,  6'd1);
		offer_query(6'd1,  6'd2);
		offer_query(6'd2,  6'd1);
		offer_query(6'd5,  6'd6);
		offer_query(6'd10, 6'd5);
		offer_query(6'd63, 6'd0);
		offer_query(6'd63, 6'd63);
		offer_query(6'd63, 6'd31);
		offer_query(6'd63, 6'd32);
		offer_query(6'd63, 6'd62);
		offer_query(6'd62, 6'd31);
		offer_query(6'd42, 6'd21);
		offer_query(6'd21, 6'd42);
		offer_query(6'd62, 6'd63);
	endtask

	// The receiver holds off while queries keep coming, so the result
	// register fills and the query channel stalls.
	task automatic test_receiver_hold_off();
		bcp_pkg::bcp_in_t q;
		hold_req = 1'b1;
		for (int i = 0; i < 5; i++) begin
			q.degree      = 6'($urandom_range(2, 9));
			q.coeff_index = 6'($urandom_range(0, q.degree));
			send_query(q);
		end
		while (hold_req)
			@(posedge clk);
	endtask

	// Mostly small degrees with in-range indexes, a few large degrees,
	// and some indexes past the degree.
	task automatic test_random_queries();
		logic [5:0] degree;
		logic [5:0] index;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 6) == 0)
				degree = 6'($urandom_range(0, 63));
			else
				degree = 6'($urandom_range(0, 12));
			if ($urandom_range(0, 9) == 0)
				index = 6'($urandom_range(0, 63));
			else
				index = 6'($urandom_range(0, degree));
			offer_query(degree, index);
		end
	endtask

	initial begin
		for (int i = 0; i < bcp_pkg::ROW_DEPTH; i++)
			pascal_row[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_queries();
		test_receiver_hold_off();
		test_random_queries();
		query_valid <= 1'b0;

		// Drain the outstanding results, then watch for stray beats.
		while (coeff_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bcp_pkg.sv
rtl/core/binomial_coefficient_pascal.sv
rtl/core/bcp_checker.sv
sim/tb_binomial_coefficient_pascal.sv
